/* design/ring_buffer_deque_macros.svh */
// Assertion macros used by the checker file.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define RBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted.
`define RBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed: next-cycle implication");

`endif

/* design/rbd_pkg.sv */
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W           = 32;

    typedef enum logic [1:0] {
        OP_PUSH_LEFT  = 2'd0,
        OP_PUSH_RIGHT = 2'd1,
        OP_POP_LEFT   = 2'd2,
        OP_POP_RIGHT  = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } state_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [WORD_W-1:0]   push_value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]   pop_value;
        logic                       done_res;
        logic                       now_empty;
        logic                       now_full;
    } rsp_item_t;

endpackage

/* design/ring_buffer_deque.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// cmd     | in        | cmd_valid / cmd_stall | cmd_item_t: opcode, push_value
// rsp     | out       | rsp_valid / rsp_stall | rsp_item_t: pop_value, done_res,
//         |           |                       |   now_empty, now_full
// For each item the store is accessed at the accept edge and its
// registered read data forms the result in the cycle after.
// One item is in flight at a time; a new item is taken once the result register
// is empty or being drained. Reset initializes pointers, count and handshake state;
// the store itself holds no reset value. A stalled result holds in its register.
module ring_buffer_deque #(
    parameter int CAPACITY = rbd_pkg::DEFAULT_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  rbd_pkg::cmd_item_t  cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rbd_pkg::rsp_item_t  rsp
);
    import rbd_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

    state_t             state_reg, state_next;
    logic [AW-1:0]      left_reg, left_next;
    logic [AW-1:0]      right_reg, right_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               pend_pop_reg, pend_pop_next;
    logic               pend_done_reg, pend_done_next;
    logic               pend_empty_reg, pend_empty_next;
    logic               pend_full_reg, pend_full_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg, rsp_next;

    logic               accept;
    logic               is_push;
    logic               is_full;
    logic               is_empty;
    logic               load_rsp;
    logic [AW-1:0]      left_inc, left_dec, right_inc, right_dec;
    logic               wr_en, rd_en;
    logic [AW-1:0]      addr;
    logic [WORD_W-1:0]  rd_data;

    rbd_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .addr    (addr),
        .wr_data (cmd.push_value),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_RESULT;
            ST_RESULT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        cmd_stall = 1'b1;
        load_rsp  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd_stall = rsp_valid_reg && rsp_stall;
            ST_RESULT: load_rsp  = 1'b1;
            default:   cmd_stall = 1'b1;
        endcase
    end

    assign accept   = cmd_valid && !cmd_stall;
    assign is_push  = (cmd.opcode == OP_PUSH_LEFT) || (cmd.opcode == OP_PUSH_RIGHT);
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    assign left_inc  = (left_reg == LAST_SLOT)  ? '0 : left_reg + AW'(1);
    assign left_dec  = (left_reg == '0)         ? LAST_SLOT : left_reg - AW'(1);
    assign right_inc = (right_reg == LAST_SLOT) ? '0 : right_reg + AW'(1);
    assign right_dec = (right_reg == '0)        ? LAST_SLOT : right_reg - AW'(1);

    // Pointer update and store access at the accept edge
    always_comb
    begin
        left_next       = left_reg;
        right_next      = right_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        addr            = left_reg;
        pend_pop_next   = pend_pop_reg;
        pend_done_next  = pend_done_reg;
        pend_empty_next = pend_empty_reg;
        pend_full_next  = pend_full_reg;

        case (cmd.opcode)
            OP_PUSH_LEFT:  addr = left_reg;
            OP_PUSH_RIGHT: addr = right_reg;
            OP_POP_LEFT:   addr = left_dec;
            default:       addr = right_inc;
        endcase

        if (accept)
        begin
            if (is_push)
            begin
                wr_en = !is_full;
                if (!is_full)
                begin
                    count_next = count_reg + CW'(1);
                    if (cmd.opcode == OP_PUSH_LEFT)
                        left_next = left_inc;
                    else
                        right_next = right_dec;
                end
            end
            else
            begin
                rd_en = !is_empty;
                if (!is_empty)
                begin
                    count_next = count_reg - CW'(1);
                    if (cmd.opcode == OP_POP_LEFT)
                        left_next = left_dec;
                    else
                        right_next = right_inc;
                end
            end
            pend_pop_next   = rd_en;
            pend_done_next  = wr_en || rd_en;
            pend_empty_next = (count_next == '0);
            pend_full_next  = (count_next == FULL_CNT);
        end
    end

    // Result register: the slot is always free when the read data lands
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (load_rsp)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.pop_value = pend_pop_reg ? $signed(rd_data) : '0;
            rsp_next.done_res  = pend_done_reg;
            rsp_next.now_empty = pend_empty_reg;
            rsp_next.now_full  = pend_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            right_reg     <= LAST_SLOT;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pop_reg   <= pend_pop_next;
        pend_done_reg  <= pend_done_next;
        pend_empty_reg <= pend_empty_next;
        pend_full_reg  <= pend_full_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* design/rbd_store.sv */
`timescale 1ns / 1ps

module rbd_store #(
    parameter int DEPTH = rbd_pkg::DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic                        rd_en,
    input  logic [AW-1:0]               addr,
    input  logic [rbd_pkg::WORD_W-1:0]  wr_data,
    output logic [rbd_pkg::WORD_W-1:0]  rd_data
);
    import rbd_pkg::*;

    logic [WORD_W-1:0] store_reg [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/rbd_checker.sv */
`timescale 1ns / 1ps
`include "ring_buffer_deque_macros.svh"

module rbd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  rbd_pkg::rsp_item_t  rsp
);
    import rbd_pkg::*;

    logic cmd_take;
    logic rsp_hold;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign rsp_hold = rsp_valid && rsp_stall;

    // Stalled result item holds
    `RBD_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_hold, rsp_valid && $stable(rsp))

    // Every accepted item shows its result after the store read register, then the result register
    `RBD_ASSERT_NEXT(a_cmd_to_rsp, clk, rst_n, cmd_take, ##1 rsp_valid)

    // A failed pop hands back zero, so any non-zero word means success
    `RBD_ASSERT_NOW(a_value_done, clk, rst_n, rsp_valid && (rsp.pop_value != '0), rsp.done_res)

    // Empty and full never coincide
    `RBD_ASSERT_NOW(a_empty_full, clk, rst_n, rsp_valid, !(rsp.now_empty && rsp.now_full))

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);
